### rtl/core/swam_pkg.sv
// Shared types and constants for the sliding window anagram matcher.
// Used by swam_hist, swam_ring and sliding_window_anagram_match.
// No dependencies.
package swam_pkg;

   localparam int WINDOW_CAPACITY = 64;
   localparam int ALPHABET_SIZE   = 26;

   localparam int LETTER_W = 7;
   localparam int OPCODE_W = 2;
   localparam int IDX_W    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int PTR_W    = (WINDOW_CAPACITY > 1) ? $clog2(WINDOW_CAPACITY) : 1;
   localparam int CNT_W    = $clog2(WINDOW_CAPACITY + 1);
   localparam int DIFF_W   = CNT_W + 1;
   localparam int MM_W     = $clog2(ALPHABET_SIZE + 1);

   localparam logic [LETTER_W-1:0] LETTER_BASE = LETTER_W'(97);

   typedef enum logic [OPCODE_W-1:0] {
      OP_START   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2,
      OP_QUERY   = 2'd3
   } opcode_type;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   // Histogram update request for one accepted transaction.
   typedef struct packed {
      logic    clear;
      logic    inc_en;
      idx_type inc_idx;
      logic    dec_en;
      idx_type dec_idx;
   } hist_ctrl_type;

endpackage

### rtl/core/swam_hist.sv
// Signed difference histogram (pattern count minus window count) kept as one
// register cell per letter, plus the count of letters whose difference is nonzero.
// Depends on swam_pkg.
module swam_hist (
   input  logic                        clock,
   input  logic                        reset,
   input  swam_pkg::hist_ctrl_type     ctrl,
   output logic [swam_pkg::MM_W-1:0]   mismatch_next
);
   import swam_pkg::*;

   diff_type                 cell_ff [ALPHABET_SIZE];
   diff_type                 cell_in [ALPHABET_SIZE];
   logic [MM_W-1:0]          mismatch_ff;
   logic [MM_W-1:0]          mismatch_in;
   logic [ALPHABET_SIZE-1:0] inc_only;
   logic [ALPHABET_SIZE-1:0] dec_only;
   logic [ALPHABET_SIZE-1:0] went_nz;
   logic [ALPHABET_SIZE-1:0] went_z;
   logic                     nz_inc;
   logic                     nz_dec;
   logic                     z_inc;
   logic                     z_dec;

   // Each cell decides its own update; when both the entering and the leaving
   // letter hit the same cell the two changes cancel.
   always_comb begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         inc_only[i] = ctrl.inc_en && (ctrl.inc_idx == IDX_W'(i))
                       && !(ctrl.dec_en && (ctrl.dec_idx == IDX_W'(i)));
         dec_only[i] = ctrl.dec_en && (ctrl.dec_idx == IDX_W'(i))
                       && !(ctrl.inc_en && (ctrl.inc_idx == IDX_W'(i)));
         if (inc_only[i]) begin
            cell_in[i] = cell_ff[i] + DIFF_W'(1);
         end else if (dec_only[i]) begin
            cell_in[i] = cell_ff[i] - DIFF_W'(1);
         end else begin
            cell_in[i] = cell_ff[i];
         end
         went_nz[i] = (cell_ff[i] == '0) && (cell_in[i] != '0);
         went_z[i]  = (cell_ff[i] != '0) && (cell_in[i] == '0);
      end
   end

   // At most one cell moves up and one moves down, so an OR finds each event.
   assign nz_inc = |(went_nz & inc_only);
   assign nz_dec = |(went_nz & dec_only);
   assign z_inc  = |(went_z & inc_only);
   assign z_dec  = |(went_z & dec_only);

   always_comb begin
      if (ctrl.clear) begin
         mismatch_in = '0;
      end else begin
         mismatch_in = mismatch_ff + MM_W'(nz_inc) + MM_W'(nz_dec)
                       - MM_W'(z_inc) - MM_W'(z_dec);
      end
   end

   assign mismatch_next = mismatch_in;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         mismatch_ff <= '0;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            cell_ff[i] <= '0;
         end
      end else begin
         mismatch_ff <= mismatch_in;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

endmodule

### rtl/core/swam_ring.sv
// Window ring memory holding the letter indexes of the last text letters, with
// a registered read that prefetches the letter leaving the window next.
// Depends on swam_pkg.
module swam_ring (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       wr_en,
   input  swam_pkg::idx_type          wr_idx,
   input  logic [swam_pkg::CNT_W-1:0] pattern_length_in,
   output swam_pkg::idx_type          evict_idx
);
   import swam_pkg::*;

   idx_type            ring_mem [WINDOW_CAPACITY];
   logic [PTR_W-1:0]   ring_ptr_ff;
   logic [PTR_W-1:0]   ring_ptr_in;
   logic [CNT_W:0]     rd_sum;
   logic [PTR_W-1:0]   rd_addr;
   idx_type            rd_data_ff;

   always_comb begin
      if (clear) begin
         ring_ptr_in = '0;
      end else if (wr_en) begin
         ring_ptr_in = (ring_ptr_ff == PTR_W'(WINDOW_CAPACITY - 1)) ? '0
                       : ring_ptr_ff + PTR_W'(1);
      end else begin
         ring_ptr_in = ring_ptr_ff;
      end
   end

   // Slot of the oldest window letter as seen by the next transaction.
   always_comb begin
      if ((CNT_W + 1)'(ring_ptr_in) >= (CNT_W + 1)'(pattern_length_in)) begin
         rd_sum = (CNT_W + 1)'(ring_ptr_in) - (CNT_W + 1)'(pattern_length_in);
      end else begin
         rd_sum = (CNT_W + 1)'(ring_ptr_in) + (CNT_W + 1)'(WINDOW_CAPACITY)
                  - (CNT_W + 1)'(pattern_length_in);
      end
      rd_addr = rd_sum[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ptr_ff <= '0;
      end else begin
         ring_ptr_ff <= ring_ptr_in;
      end
   end

   // A one-letter window reads the slot being written now, so it is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[ring_ptr_ff] <= wr_idx;
      end
      if (wr_en && (rd_addr == ring_ptr_ff)) begin
         rd_data_ff <= wr_idx;
      end else begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign evict_idx = rd_data_ff;

endmodule

### rtl/core/sliding_window_anagram_match.sv
// Top level of the sliding window anagram matcher.
// Depends on swam_pkg, swam_hist and swam_ring.
//
// Usage: each request transaction carries an opcode and a letter. Start clears
// the block, pattern letters build the letter histogram (only before the first
// text letter), text letters slide a window as long as the pattern over the
// text, and query only reports. Every request yields exactly one response
// transaction with window_match, found (sticky) and overflow (sticky).
// Latency: the response is valid in the cycle after the request is accepted.
// Throughput: one request per cycle. The histogram is a row of per-letter
// cells updated in parallel, and the letter leaving the window is prefetched
// from the ring memory by its registered read port the cycle before it is used.
// The response sits in an output register; a new request is taken while it
// waits if the receiver takes it in the same cycle, so a stalled receiver
// holds the response and stops further requests.
// Reset clears all control state and the histogram at once; the ring memory is
// not cleared, since a slot is always written before it leaves the window.
module sliding_window_anagram_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swam_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [swam_pkg::LETTER_W-1:0] req_letter,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_window_match,
   output logic                          rsp_found,
   output logic                          rsp_overflow
);
   import swam_pkg::*;

   logic              accept;
   opcode_type        opcode;
   logic [LETTER_W-1:0] letter_off;
   logic              idx_ok;
   idx_type           idx;
   idx_type           evict_idx;
   logic [MM_W-1:0]   mismatch_next;
   hist_ctrl_type     hist_ctrl;
   logic              is_start;
   logic              pat_do;
   logic              ovf_set;
   logic              txt_do;
   logic              evict;
   logic              match;

   logic [CNT_W-1:0]  pattern_length_ff;
   logic [CNT_W-1:0]  pattern_length_in;
   logic [CNT_W-1:0]  text_seen_ff;
   logic [CNT_W-1:0]  text_seen_in;
   logic              found_ff;
   logic              found_in;
   logic              overflow_ff;
   logic              overflow_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_match_ff;
   logic              rsp_found_ff;
   logic              rsp_overflow_ff;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign opcode    = opcode_type'(req_opcode);

   assign letter_off = req_letter - LETTER_BASE;
   assign idx_ok     = (req_letter >= LETTER_BASE)
                       && (letter_off < LETTER_W'(ALPHABET_SIZE));
   assign idx        = letter_off[IDX_W-1:0];

   always_comb begin
      is_start = 1'b0;
      pat_do   = 1'b0;
      ovf_set  = 1'b0;
      txt_do   = 1'b0;
      unique case (opcode)
         OP_START: begin
            is_start = accept;
         end
         OP_PATTERN: begin
            if (accept && idx_ok && (text_seen_ff == '0)) begin
               if (pattern_length_ff >= CNT_W'(WINDOW_CAPACITY)) begin
                  ovf_set = 1'b1;
               end else begin
                  pat_do = 1'b1;
               end
            end
         end
         OP_TEXT: begin
            txt_do = accept && idx_ok && (pattern_length_ff != '0);
         end
         OP_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   assign evict = txt_do && (text_seen_ff >= pattern_length_ff);

   always_comb begin
      hist_ctrl.clear   = is_start;
      hist_ctrl.inc_en  = pat_do || evict;
      hist_ctrl.inc_idx = evict ? evict_idx : idx;
      hist_ctrl.dec_en  = txt_do;
      hist_ctrl.dec_idx = idx;
   end

   always_comb begin
      pattern_length_in = pattern_length_ff;
      text_seen_in      = text_seen_ff;
      overflow_in       = overflow_ff;
      if (is_start) begin
         pattern_length_in = '0;
         text_seen_in      = '0;
         overflow_in       = 1'b0;
      end else begin
         if (pat_do) begin
            pattern_length_in = pattern_length_ff + CNT_W'(1);
         end
         if (ovf_set) begin
            overflow_in = 1'b1;
         end
         if (txt_do && (text_seen_ff < CNT_W'(WINDOW_CAPACITY))) begin
            text_seen_in = text_seen_ff + CNT_W'(1);
         end
      end
   end

   assign match    = (text_seen_in >= pattern_length_in) && (mismatch_next == '0);
   assign found_in = (found_ff && !is_start) || match;

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   swam_hist u_hist (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (hist_ctrl),
      .mismatch_next (mismatch_next)
   );

   swam_ring u_ring (
      .clock             (clock),
      .reset             (reset),
      .clear             (is_start),
      .wr_en             (txt_do),
      .wr_idx            (idx),
      .pattern_length_in (pattern_length_in),
      .evict_idx         (evict_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         text_seen_ff      <= '0;
         found_ff          <= 1'b0;
         overflow_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pattern_length_ff <= pattern_length_in;
            text_seen_ff      <= text_seen_in;
            found_ff          <= found_in;
            overflow_ff       <= overflow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_match_ff    <= match;
         rsp_found_ff    <= found_in;
         rsp_overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_match = rsp_match_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   a_text_seen_bound: assert property (@(posedge clock) disable iff (reset)
      text_seen_ff <= CNT_W'(WINDOW_CAPACITY))
      else $error("text count exceeds window capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (pattern_length_ff == CNT_W'(WINDOW_CAPACITY)))
      else $error("overflow set while pattern is not full");

   a_start_matches: assert property (@(posedge clock) disable iff (reset)
      is_start |=> (rsp_valid_ff && rsp_match_ff && rsp_found_ff && !rsp_overflow_ff))
      else $error("start transaction did not report an empty pattern match");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_match_ff) |-> rsp_found_ff)
      else $error("window match reported without found");

endmodule

### dv/tb_sliding_window_anagram_match.sv
// Testbench for sliding_window_anagram_match: directed and random transactions,
// with every response checked against a behavioral predictor of the matcher.
// Depends on swam_pkg and the sliding_window_anagram_match RTL.
module tb_sliding_window_anagram_match;
   timeunit 1ns;
   timeprecision 1ps;
   import swam_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 60;

   typedef logic [LETTER_W-1:0] letter_type;

   typedef struct {
      bit window_match;
      bit found;
      bit overflow;
   } anagram_status_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [OPCODE_W-1:0] req_opcode;
   letter_type       req_letter;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_window_match;
   logic             rsp_found;
   logic             rsp_overflow;

   // Predictor state: pattern count minus window count per letter.
   int letter_balance [ALPHABET_SIZE];
   int window_letters [WINDOW_CAPACITY];
   int unbalanced_letters;
   int pattern_len;
   int text_count;
   int window_head;
   bit found_seen;
   bit pattern_overflowed;

   anagram_status_type pending_status [$];
   anagram_status_type status_due;

   int error_count = 0;
   int items_sent = 0;
   int responses_seen = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   sliding_window_anagram_match uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_letter       (req_letter),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_match (rsp_window_match),
      .rsp_found        (rsp_found),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic letter_type letter_at(int i);
      return letter_type'(int'(LETTER_BASE) + i);
   endfunction

   function automatic void clear_matcher();
      foreach (letter_balance[i]) letter_balance[i] = 0;
      foreach (window_letters[i]) window_letters[i] = 0;
      unbalanced_letters = 0;
      pattern_len = 0;
      text_count = 0;
      window_head = 0;
      found_seen = 1'b0;
      pattern_overflowed = 1'b0;
   endfunction

   function automatic void shift_balance(int idx, int delta);
      bit was_zero;
      was_zero = (letter_balance[idx] == 0);
      letter_balance[idx] += delta;
      if (was_zero && letter_balance[idx] != 0)
         unbalanced_letters++;
      else if (!was_zero && letter_balance[idx] == 0)
         unbalanced_letters--;
   endfunction

   function automatic anagram_status_type predict_status(opcode_type op, letter_type letter);
      anagram_status_type st;
      int idx;
      bit letter_ok;
      idx = int'(letter) - int'(LETTER_BASE);
      letter_ok = (idx >= 0) && (idx < ALPHABET_SIZE);
      case (op)
         OP_START: clear_matcher();
         OP_PATTERN: begin
            if (letter_ok && text_count == 0) begin
               if (pattern_len >= WINDOW_CAPACITY) begin
                  pattern_overflowed = 1'b1;
               end else begin
                  shift_balance(idx, 1);
                  pattern_len++;
               end
            end
         end
         OP_TEXT: begin
            if (letter_ok && pattern_len != 0) begin
               shift_balance(idx, -1);
               // Once the window is full, the oldest letter leaves it.
               if (text_count >= pattern_len)
                  shift_balance(window_letters[(window_head + WINDOW_CAPACITY - pattern_len)
                                               % WINDOW_CAPACITY], 1);
               window_letters[window_head] = idx;
               window_head = (window_head + 1) % WINDOW_CAPACITY;
               if (text_count < WINDOW_CAPACITY)
                  text_count++;
            end
         end
         default: ;
      endcase
      st.window_match = (text_count >= pattern_len) && (unbalanced_letters == 0);
      if (st.window_match)
         found_seen = 1'b1;
      st.found = found_seen;
      st.overflow = pattern_overflowed;
      return st;
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t ns, response %0d: %s", $time, responses_seen, msg);
   endfunction

   function automatic void check_field(string name, logic got, bit want);
      if (got !== want)
         note_error($sformatf("%s expected %0b, got %b", name, want, got));
   endfunction

   // Offers one request transaction, after an optional random idle gap, and
   // predicts its response once it is accepted. Valid stays high between
   // back-to-back transactions.
   task automatic send_item(opcode_type op, letter_type letter);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_letter <= letter;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status.push_back(predict_status(op, letter));
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_status.size() == 0) begin
            note_error("response transaction with no request outstanding");
         end else begin
            status_due = pending_status.pop_front();
            check_field("window_match", rsp_window_match, status_due.window_match);
            check_field("found", rsp_found, status_due.found);
            check_field("overflow", rsp_overflow, status_due.overflow);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    <= hold_request - 1;
         hold_request <= 0;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_sliding_window_anagram_match: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_directed_basics();
      send_item(OP_QUERY, letter_at(23));
      send_item(OP_START, '0);
      send_item(OP_TEXT, letter_at(16));
      send_item(OP_PATTERN, letter_type'(96));
      send_item(OP_PATTERN, letter_type'(123));
      send_item(OP_PATTERN, letter_type'(0));
      send_item(OP_PATTERN, letter_type'(127));
      send_item(OP_PATTERN, letter_at(0));
      send_item(OP_PATTERN, letter_at(25));
      send_item(OP_PATTERN, letter_at(0));
      send_item(OP_TEXT, letter_type'(96));
      send_item(OP_TEXT, letter_type'(123));
      send_item(OP_TEXT, letter_at(25));
      send_item(OP_TEXT, letter_at(0));
      send_item(OP_TEXT, letter_at(1));
      send_item(OP_TEXT, letter_at(0));
      send_item(OP_TEXT, letter_at(25));
      send_item(OP_TEXT, letter_at(0));
      send_item(OP_TEXT, letter_at(1));
      send_item(OP_PATTERN, letter_at(2));
      send_item(OP_QUERY, '1);
      send_item(OP_START, '1);
      send_item(OP_PATTERN, letter_at(0));
      send_item(OP_TEXT, letter_at(0));
      send_item(OP_QUERY, '0);
   endtask

   // Fills the pattern to capacity, pushes past it, then matches a full-size
   // window and keeps sliding once the text count has saturated.
   task automatic test_pattern_overflow();
      int pattern_idx [WINDOW_CAPACITY];
      send_item(OP_START, '0);
      foreach (pattern_idx[i]) begin
         pattern_idx[i] = $urandom_range(ALPHABET_SIZE - 1);
         send_item(OP_PATTERN, letter_at(pattern_idx[i]));
      end
      send_item(OP_PATTERN, letter_type'(5));
      send_item(OP_PATTERN, letter_at(3));
      send_item(OP_PATTERN, letter_at(25));
      for (int i = WINDOW_CAPACITY - 1; i >= 0; i--)
         send_item(OP_TEXT, letter_at(pattern_idx[i]));
      for (int i = 0; i < 20; i++)
         send_item(OP_TEXT, letter_at(pattern_idx[$urandom_range(WINDOW_CAPACITY - 1)]));
      send_item(OP_QUERY, '0);
   endtask

   task automatic test_random_sequences(int quota, int idle_pct, int stall_pct);
      int target;
      int plen;
      int tlen;
      int span;
      int base;
      int pick;
      sender_idle_pct = idle_pct;
      receiver_stall_pct <= stall_pct;
      target = items_sent + quota;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 88) begin
            // Search: start, pattern, then text mixed with queries and random
            // items, mostly over a narrow alphabet so that windows match often.
            pick = $urandom_range(99);
            if (pick < 85)
               plen = $urandom_range(6, 1);
            else if (pick < 95)
               plen = $urandom_range(20, 7);
            else
               plen = $urandom_range(WINDOW_CAPACITY + 6, WINDOW_CAPACITY - 14);
            span = ($urandom_range(99) < 20) ? ALPHABET_SIZE : $urandom_range(4, 1);
            base = $urandom_range(ALPHABET_SIZE - span);
            send_item(OP_START, letter_type'($urandom_range(127)));
            for (int i = 0; i < plen; i++)
               send_item(OP_PATTERN, letter_at(base + $urandom_range(span - 1)));
            tlen = $urandom_range(3 * plen + 8);
            for (int i = 0; i < tlen; i++) begin
               pick = $urandom_range(99);
               if (pick < 90)
                  send_item(OP_TEXT, letter_at(base + $urandom_range(span - 1)));
               else if (pick < 94)
                  send_item(OP_QUERY, letter_type'($urandom_range(127)));
               else if (pick < 97)
                  send_item(opcode_type'($urandom_range(3)), letter_type'($urandom_range(127)));
               else
                  send_item(OP_PATTERN, letter_at(base + $urandom_range(span - 1)));
            end
         end else begin
            for (int i = 0; i < 10; i++)
               send_item(opcode_type'($urandom_range(3)), letter_type'($urandom_range(127)));
         end
      end
   endtask

   // The receiver holds off while requests keep coming, so the output
   // register fills and the block must stall its request channel.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      hold_request <= HOLD_CYCLES;
      send_item(OP_START, '0);
      for (int i = 0; i < 3; i++)
         send_item(OP_PATTERN, letter_at($urandom_range(2)));
      for (int i = 0; i < 36; i++)
         send_item(OP_TEXT, letter_at($urandom_range(2)));
   endtask

   initial begin
      clear_matcher();
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_opcode <= OP_QUERY;
      req_letter <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_pattern_overflow();
      test_random_sequences(450, 0, 0);
      test_random_sequences(450, 58, 0);
      test_random_sequences(450, 0, 58);
      test_random_sequences(450, 29, 29);
      test_backpressure();

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_sliding_window_anagram_match: done, clean");
      else
         $display("tb_sliding_window_anagram_match: done, errors");
      $finish;
   end

endmodule

### files.f
rtl/core/swam_pkg.sv
rtl/core/swam_hist.sv
rtl/core/swam_ring.sv
rtl/core/sliding_window_anagram_match.sv
dv/tb_sliding_window_anagram_match.sv
